@@ sv/max_pool_2d_stream_assert.svh @@
// Assertion macros for the max pooling block.
`ifndef MAX_POOL_2D_STREAM_ASSERT_SVH
`define MAX_POOL_2D_STREAM_ASSERT_SVH
`ifndef SYNTHESIS
`define MPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MPS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MPS_ASSERT(lbl, prop, msg)
`define MPS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ sv/mp2s_pkg.sv @@
`default_nettype none

package mp2s_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_KERNEL  = 8;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned DIM_LIMIT   = 1024;

  localparam int unsigned CFG_W  = 11;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned POS_W  = $clog2(DIM_LIMIT);
  localparam int unsigned DIM_W  = $clog2(DIM_LIMIT + 1);
  localparam int unsigned BANK_W = $clog2(MAX_KERNEL);
  localparam int unsigned KER_W  = $clog2(MAX_KERNEL + 1);
  localparam int unsigned SUM_W  = ((DIM_W > WID_W) ? DIM_W : WID_W) + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CFG_W-1:0]  cfg_data_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [WID_W-1:0]  wid_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [BANK_W-1:0] bank_t;
  typedef logic [KER_W-1:0]  ker_t;
  typedef logic [BANK_W-1:0] phase_t;
  typedef logic [SUM_W-1:0]  sum_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_CHANNELS,
    CFG_HEIGHT,
    CFG_WIDTH,
    CFG_KROWS,
    CFG_KCOLS,
    CFG_SROWS,
    CFG_SCOLS
  } cfg_idx_e;

  typedef struct packed {
    sample_t sample;
    bank_t   bank;
    logic    rows_full;
    logic    emit;
    logic    last;
  } s1_t;

  typedef struct packed {
    logic emit;
    logic last;
  } s2_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic int unsigned clamp_cfg(input cfg_data_t v, input int unsigned hi);
    int unsigned x;
    x = 32'(v);
    if (x == 0) begin
      return 1;
    end
    if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

endpackage

`default_nettype wire

@@ sv/max_pool_2d_stream.sv @@
`default_nettype none

`include "max_pool_2d_stream_assert.svh"

// Streaming 2-D max pooling, valid windows only. Samples of a channel-major
// tensor enter one per cycle while in_stall_o is low, each plane in raster
// order; a pooled result leaves after the sample that completes its window
// passes the read of the line store, the vertical max and the horizontal max.
// The line store is eight banks of one row each, written at the current
// column and read at that same column in all banks while the input is not
// stalled, which is what allows a new sample in every such cycle. The store
// needs no clearing after reset; the block accepts samples from the first cycle.
// Configuration registers are written through a separate port (always ready);
// any write to a known index restarts the tensor, and writes belong to idle
// periods only. last_of_tensor_o marks the final result of the last plane.
module max_pool_2d_stream (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [mp2s_pkg::IDX_W-1:0]           cfg_index_i,
  input  wire  [mp2s_pkg::CFG_W-1:0]           cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  signed [mp2s_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic signed [mp2s_pkg::SAMPLE_BITS-1:0] pooled_value_o,
  output logic                                 last_of_tensor_o
);

  // configuration, stored clamped
  mp2s_pkg::dim_t nch_q, h_q;
  mp2s_pkg::wid_t w_q;
  mp2s_pkg::ker_t kr_q, kc_q, sr_q, sc_q;

  // position counters
  mp2s_pkg::pos_t   r_q, r_d, ch_q, ch_d;
  mp2s_pkg::col_t   c_q, c_d;
  mp2s_pkg::phase_t rph_q, rph_d, cph_q, cph_d;

  // pipeline
  logic            s1_valid_q, s2_valid_q, out_valid_q;
  mp2s_pkg::s1_t   s1_d, s1_q;
  mp2s_pkg::s2_t   s2_q;
  mp2s_pkg::sample_t out_value_q;
  logic            out_last_q;
  mp2s_pkg::sample_t rd_q  [mp2s_pkg::MAX_KERNEL];
  mp2s_pkg::sample_t col_q [mp2s_pkg::MAX_KERNEL];
  mp2s_pkg::sample_t line_mem_q [mp2s_pkg::MAX_KERNEL][mp2s_pkg::MAX_WIDTH];
  mp2s_pkg::sample_t vmax, hmax;

  logic ready1, ready2, ready_out, accept, cfg_hit;
  logic rows_full, cols_full, col_end, row_end, ch_end;
  mp2s_pkg::sum_t r_ext, c_ext, ch_ext, one_s;
  mp2s_pkg::ker_t cph_inc, rph_inc;

  assign ready_out   = !out_valid_q || !out_stall_i;
  assign ready2      = !s2_valid_q || ready_out;
  assign ready1      = !s1_valid_q || ready2;
  assign in_stall_o  = !ready1;
  assign accept      = in_valid_i && ready1;
  assign cfg_ready_o = 1'b1;
  assign cfg_hit     = cfg_valid_i && (cfg_index_i <= mp2s_pkg::CFG_SCOLS);

  assign out_valid_o      = out_valid_q;
  assign pooled_value_o   = out_value_q;
  assign last_of_tensor_o = out_last_q;

  // item decode and counter advance
  assign one_s  = mp2s_pkg::sum_t'(1);
  assign r_ext  = mp2s_pkg::sum_t'(r_q);
  assign c_ext  = mp2s_pkg::sum_t'(c_q);
  assign ch_ext = mp2s_pkg::sum_t'(ch_q);

  assign rows_full = (r_ext + one_s) >= mp2s_pkg::sum_t'(kr_q);
  assign cols_full = (c_ext + one_s) >= mp2s_pkg::sum_t'(kc_q);
  assign col_end   = (c_ext + one_s) == mp2s_pkg::sum_t'(w_q);
  assign row_end   = (r_ext + one_s) == mp2s_pkg::sum_t'(h_q);
  assign ch_end    = (ch_ext + one_s) == mp2s_pkg::sum_t'(nch_q);
  assign cph_inc   = mp2s_pkg::ker_t'(cph_q) + mp2s_pkg::ker_t'(1);
  assign rph_inc   = mp2s_pkg::ker_t'(rph_q) + mp2s_pkg::ker_t'(1);

  always_comb begin
    s1_d.sample    = sample_i;
    s1_d.bank      = r_q[mp2s_pkg::BANK_W-1:0];
    s1_d.rows_full = rows_full;
    s1_d.emit      = rows_full && cols_full && (rph_q == '0) && (cph_q == '0);
    s1_d.last      = ch_end
                     && ((r_ext + mp2s_pkg::sum_t'(sr_q)) >= mp2s_pkg::sum_t'(h_q))
                     && ((c_ext + mp2s_pkg::sum_t'(sc_q)) >= mp2s_pkg::sum_t'(w_q));
  end

  always_comb begin
    r_d   = r_q;
    ch_d  = ch_q;
    rph_d = rph_q;
    c_d   = c_q + mp2s_pkg::col_t'(1);
    cph_d = cph_q;
    if (cols_full) begin
      cph_d = (cph_inc == sc_q) ? '0 : cph_inc[mp2s_pkg::BANK_W-1:0];
    end
    if (col_end) begin
      c_d   = '0;
      cph_d = '0;
      if (rows_full) begin
        rph_d = (rph_inc == sr_q) ? '0 : rph_inc[mp2s_pkg::BANK_W-1:0];
      end
      r_d = r_q + mp2s_pkg::pos_t'(1);
      if (row_end) begin
        r_d   = '0;
        rph_d = '0;
        ch_d  = ch_end ? '0 : ch_q + mp2s_pkg::pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nch_q <= mp2s_pkg::dim_t'(1);
      h_q   <= mp2s_pkg::dim_t'(8);
      w_q   <= mp2s_pkg::wid_t'(8);
      kr_q  <= mp2s_pkg::ker_t'(2);
      kc_q  <= mp2s_pkg::ker_t'(2);
      sr_q  <= mp2s_pkg::ker_t'(2);
      sc_q  <= mp2s_pkg::ker_t'(2);
      r_q   <= '0;
      c_q   <= '0;
      ch_q  <= '0;
      rph_q <= '0;
      cph_q <= '0;
    end else if (cfg_hit) begin
      r_q   <= '0;
      c_q   <= '0;
      ch_q  <= '0;
      rph_q <= '0;
      cph_q <= '0;
      case (mp2s_pkg::cfg_idx_e'(cfg_index_i))
        mp2s_pkg::CFG_CHANNELS: begin
          nch_q <= mp2s_pkg::dim_t'(mp2s_pkg::clamp_cfg(cfg_data_i, mp2s_pkg::DIM_LIMIT));
        end
        mp2s_pkg::CFG_HEIGHT: begin
          h_q <= mp2s_pkg::dim_t'(mp2s_pkg::clamp_cfg(cfg_data_i, mp2s_pkg::DIM_LIMIT));
        end
        mp2s_pkg::CFG_WIDTH: begin
          w_q <= mp2s_pkg::wid_t'(mp2s_pkg::clamp_cfg(cfg_data_i, mp2s_pkg::MAX_WIDTH));
        end
        mp2s_pkg::CFG_KROWS: begin
          kr_q <= mp2s_pkg::ker_t'(mp2s_pkg::clamp_cfg(cfg_data_i, mp2s_pkg::MAX_KERNEL));
        end
        mp2s_pkg::CFG_KCOLS: begin
          kc_q <= mp2s_pkg::ker_t'(mp2s_pkg::clamp_cfg(cfg_data_i, mp2s_pkg::MAX_KERNEL));
        end
        mp2s_pkg::CFG_SROWS: begin
          sr_q <= mp2s_pkg::ker_t'(mp2s_pkg::clamp_cfg(cfg_data_i, mp2s_pkg::MAX_KERNEL));
        end
        mp2s_pkg::CFG_SCOLS: begin
          sc_q <= mp2s_pkg::ker_t'(mp2s_pkg::clamp_cfg(cfg_data_i, mp2s_pkg::MAX_KERNEL));
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      r_q   <= r_d;
      c_q   <= c_d;
      ch_q  <= ch_d;
      rph_q <= rph_d;
      cph_q <= cph_d;
    end
  end

  // line store: one bank per row modulo the kernel limit
  for (genvar b = 0; b < mp2s_pkg::MAX_KERNEL; b++) begin : g_bank
    always_ff @(posedge clk_i) begin
      if (accept && (r_q[mp2s_pkg::BANK_W-1:0] == mp2s_pkg::bank_t'(b))) begin
        line_mem_q[b][c_q] <= sample_i;
      end
      if (ready1) begin
        rd_q[b] <= line_mem_q[b][c_q];
      end
    end
  end

  // vertical max over the kernel rows ending at the current row
  always_comb begin
    mp2s_pkg::bank_t   row_dist;
    mp2s_pkg::sample_t v;
    vmax = s1_q.sample;
    for (int b = 0; b < mp2s_pkg::MAX_KERNEL; b++) begin
      row_dist = s1_q.bank - mp2s_pkg::bank_t'(b);
      v        = (row_dist == '0) ? s1_q.sample : rd_q[b];
      if ((mp2s_pkg::ker_t'(row_dist) < kr_q) && (v > vmax)) begin
        vmax = v;
      end
    end
  end

  // horizontal max over the latest column maxima
  always_comb begin
    hmax = col_q[0];
    for (int j = 1; j < mp2s_pkg::MAX_KERNEL; j++) begin
      if ((mp2s_pkg::ker_t'(j) < kc_q) && (col_q[j] > hmax)) begin
        hmax = col_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready1) begin
        s1_valid_q <= in_valid_i;
      end
      if (ready2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (ready_out) begin
        out_valid_q <= s2_valid_q && s2_q.emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (ready2) begin
      s2_q.emit <= s1_q.emit;
      s2_q.last <= s1_q.last;
    end
    if (s1_valid_q && ready2 && s1_q.rows_full) begin
      col_q[0] <= vmax;
      for (int j = 1; j < mp2s_pkg::MAX_KERNEL; j++) begin
        col_q[j] <= col_q[j-1];
      end
    end
    if (ready_out) begin
      out_value_q <= hmax;
      out_last_q  <= s2_q.last;
    end
  end

  `MPS_ASSERT(a_stall_only_when_blocked, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with free output")
  `MPS_ASSERT(a_col_phase_range, mp2s_pkg::ker_t'(cph_q) < sc_q, "column phase beyond stride")
  `MPS_ASSERT(a_row_phase_range, mp2s_pkg::ker_t'(rph_q) < sr_q, "row phase beyond stride")
  `MPS_ASSERT_NEVER(a_pos_range, (r_ext >= mp2s_pkg::sum_t'(h_q)) || (c_ext >= mp2s_pkg::sum_t'(w_q)) || (ch_ext >= mp2s_pkg::sum_t'(nch_q)), "position outside tensor")

endmodule

`default_nettype wire

@@ tb/tb_max_pool_2d_stream.sv @@
`timescale 1ns / 1ps

module tb_max_pool_2d_stream;
  import mp2s_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_ITEMS   = 600;
  localparam int unsigned CLAMP_ITEMS    = 96;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned MAX_GAP        = 13;
  localparam int unsigned REG_COUNT      = 7;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [IDX_W-1:0] CFG_BAD_IDX = 3'd7;
  localparam sample_t S_MAX = 16'sh7fff;
  localparam sample_t S_MIN = 16'sh8000;

  typedef struct packed {
    sample_t value;
    logic    last;
  } pooled_t;

  typedef struct packed {
    logic             is_reg;
    logic [IDX_W-1:0] idx;
    cfg_data_t        data;
    sample_t          sample;
    logic             typed;
    logic             has_res;
    sample_t          res;
    logic             res_last;
  } step_row_t;

  localparam int DIR_N = 30;
  localparam step_row_t DIR_TAB [DIR_N] = '{
    // reset setting: 8x8 plane, 2x2 window, stride 2
    '{1'b0, '0, '0, S_MAX,         1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, S_MIN,         1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, S_MIN,         1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, S_MIN,         1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, -16'sd1,       1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, 16'sd0,        1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, 16'sd1,        1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, -16'sd2,       1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, S_MIN,         1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, S_MIN,         1'b1, 1'b1, S_MAX,         1'b0},
    '{1'b0, '0, '0, S_MIN,         1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, S_MIN,         1'b1, 1'b1, S_MIN,         1'b0},
    '{1'b0, '0, '0, 16'sd5,        1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, -16'sd5,       1'b1, 1'b1, 16'sd5,        1'b0},
    '{1'b0, '0, '0, S_MIN,         1'b1, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, 16'sd16384,    1'b1, 1'b1, 16'sd16384,    1'b0},
    '{1'b0, '0, '0, 16'sd100,      1'b0, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, -16'sd100,     1'b0, 1'b0, '0,            1'b0},
    '{1'b0, '0, '0, 16'sd7,        1'b0, 1'b0, '0,            1'b0},
    // unknown index: no effect, the row carries on
    '{1'b1, CFG_BAD_IDX,  11'd1, '0, 1'b0, 1'b0, '0,          1'b0},
    '{1'b0, '0, '0, 16'sd9,        1'b0, 1'b0, '0,            1'b0},
    // mid-plane writes restart the tensor; zero count acts as one
    '{1'b1, CFG_CHANNELS, 11'd0, '0, 1'b0, 1'b0, '0,          1'b0},
    '{1'b1, CFG_HEIGHT,   11'd1, '0, 1'b0, 1'b0, '0,          1'b0},
    '{1'b1, CFG_WIDTH,    11'd1, '0, 1'b0, 1'b0, '0,          1'b0},
    '{1'b1, CFG_KROWS,    11'd1, '0, 1'b0, 1'b0, '0,          1'b0},
    '{1'b1, CFG_KCOLS,    11'd1, '0, 1'b0, 1'b0, '0,          1'b0},
    '{1'b0, '0, '0, S_MIN,         1'b1, 1'b1, S_MIN,         1'b1},
    '{1'b0, '0, '0, S_MAX,         1'b1, 1'b1, S_MAX,         1'b1},
    // window taller than the plane
    '{1'b1, CFG_KROWS,    11'd2, '0, 1'b0, 1'b0, '0,          1'b0},
    '{1'b0, '0, '0, 16'sd5,        1'b1, 1'b0, '0,            1'b0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [IDX_W-1:0]       cfg_index_i;
  cfg_data_t              cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  sample_t                sample_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  sample_t                pooled_value_o;
  logic                   last_of_tensor_o;

  max_pool_2d_stream u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pooled_value_o   (pooled_value_o),
    .last_of_tensor_o (last_of_tensor_o)
  );

  // pooling predictor state
  sample_t     line_mem [MAX_KERNEL][MAX_WIDTH];
  sample_t     col_peak [MAX_KERNEL];
  cfg_data_t   regs_now [REG_COUNT];
  int unsigned row_at, col_at, plane_at, row_skew, col_skew;

  pooled_t     pending [$];
  pooled_t     head;

  logic        tx_idle;
  logic        rx_idle;
  int unsigned hold_len;
  int unsigned quiet;
  int unsigned samples_in, results_out, lasts_seen, reg_writes, phases, errors;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned eff(input cfg_data_t v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  task automatic restart_tensor();
    row_at   = 0;
    col_at   = 0;
    plane_at = 0;
    row_skew = 0;
    col_skew = 0;
  endtask

  function automatic logic pool_window(input sample_t s, output sample_t peak,
                                       output logic is_last);
    int unsigned nch, h, w, kr, kc, sr, sc, r, c, ch;
    logic        rows_full;
    logic        hit;
    sample_t     v;
    nch = eff(regs_now[CFG_CHANNELS], DIM_LIMIT);
    h   = eff(regs_now[CFG_HEIGHT], DIM_LIMIT);
    w   = eff(regs_now[CFG_WIDTH], MAX_WIDTH);
    kr  = eff(regs_now[CFG_KROWS], MAX_KERNEL);
    kc  = eff(regs_now[CFG_KCOLS], MAX_KERNEL);
    sr  = eff(regs_now[CFG_SROWS], MAX_KERNEL);
    sc  = eff(regs_now[CFG_SCOLS], MAX_KERNEL);
    r   = row_at % h;
    c   = col_at % w;
    ch  = plane_at % nch;
    rows_full = (r + 1 >= kr);
    hit     = 1'b0;
    peak    = '0;
    is_last = 1'b0;
    line_mem[r % MAX_KERNEL][c] = s;
    if (rows_full) begin
      v = s;
      for (int unsigned i = 1; i < kr; i++) begin
        if (line_mem[(r - i) % MAX_KERNEL][c] > v) v = line_mem[(r - i) % MAX_KERNEL][c];
      end
      col_peak[c % MAX_KERNEL] = v;
      if (c + 1 >= kc && row_skew == 0 && col_skew == 0) begin
        peak = v;
        for (int unsigned i = 1; i < kc; i++) begin
          if (col_peak[(c - i) % MAX_KERNEL] > peak) peak = col_peak[(c - i) % MAX_KERNEL];
        end
        is_last = (ch + 1 == nch) && (r + sr >= h) && (c + sc >= w);
        hit = 1'b1;
      end
    end
    if (c + 1 >= kc) col_skew = (col_skew % sc + 1 == sc) ? 0 : col_skew % sc + 1;
    c++;
    if (c == w) begin
      c = 0;
      col_skew = 0;
      if (rows_full) row_skew = (row_skew % sr + 1 == sr) ? 0 : row_skew % sr + 1;
      r++;
      if (r == h) begin
        r = 0;
        row_skew = 0;
        ch++;
        if (ch == nch) ch = 0;
      end
    end
    row_at   = r;
    col_at   = c;
    plane_at = ch;
    return hit;
  endfunction

  task automatic flag(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input cfg_data_t val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    reg_writes++;
    if (idx <= CFG_SCOLS) begin
      regs_now[idx] = val;
      restart_tensor();
    end
  endtask

  task automatic program_regs(input cfg_data_t v [REG_COUNT]);
    settle();
    for (int i = 0; i < REG_COUNT; i++) write_reg(IDX_W'(i), v[i]);
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
    phases++;
  endtask

  task automatic send_sample(input sample_t s, input logic typed, input logic has_res,
                             input sample_t res, input logic res_last);
    int unsigned gap;
    pooled_t     got;
    logic        hit;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    samples_in++;
    hit = pool_window(s, got.value, got.last);
    if (typed) begin
      hit = has_res;
      got = '{res, res_last};
    end
    if (hit) pending.push_back(got);
  endtask

  task automatic run_stream(input int unsigned n, input logic pauses);
    sample_t s;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0: s = sample_t'($urandom_range(0, 7)) - 16'sd4;
        1: s = $urandom_range(0, 1) ? S_MAX : S_MIN;
        default: s = sample_t'($urandom);
      endcase
      send_sample(s, 1'b0, 1'b0, '0, 1'b0);
      if (pauses && $urandom_range(0, 59) == 0) settle();
    end
  endtask

  // result side
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end else begin
        n = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_out++;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected beat: value %0d last %0b",
                       pooled_value_o, last_of_tensor_o));
      end else begin
        head = pending.pop_front();
        if (pooled_value_o !== head.value || last_of_tensor_o !== head.last)
          flag($sformatf("beat %0d: expected value %0d last %0b, got value %0d last %0b",
                         results_out, head.value, head.last,
                         pooled_value_o, last_of_tensor_o));
        if (head.last) lasts_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0) ||
        (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               quiet, pending.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    cfg_data_t   setting [REG_COUNT];
    int unsigned plane;
    int unsigned burst;
    int unsigned rand_items;
    step_row_t   row;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    hold_len    = 0;
    quiet       = 0;
    rand_items  = 0;
    samples_in  = 0;
    results_out = 0;
    lasts_seen  = 0;
    reg_writes  = 0;
    phases      = 0;
    errors      = 0;
    regs_now    = '{11'd1, 11'd8, 11'd8, 11'd2, 11'd2, 11'd2, 11'd2};
    restart_tensor();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DIR_N; k++) begin
      row = DIR_TAB[k];
      if (row.is_reg) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.sample, row.typed, row.has_res, row.res, row.res_last);
      end
    end

    // oversized channel count, 1x1 planes, zero and oversized strides
    setting = '{11'd2047, 11'd1, 11'd1, 11'd1, 11'd1, 11'd0, 11'd15};
    program_regs(setting);
    run_stream(CLAMP_ITEMS, 1'b0);
    // oversized width, single row
    setting = '{11'd1, 11'd1, 11'd2047, 11'd1, 11'd2, 11'd2, 11'd2};
    program_regs(setting);
    run_stream(CLAMP_ITEMS, 1'b0);
    // oversized height, oversized window height, stride 8
    setting = '{11'd0, 11'd2047, 11'd1, 11'd15, 11'd1, 11'd8, 11'd1};
    program_regs(setting);
    run_stream(CLAMP_ITEMS, 1'b0);
    // result every beat while the result side holds off
    setting = '{11'd1, 11'd8, 11'd8, 11'd1, 11'd1, 11'd1, 11'd1};
    program_regs(setting);
    tx_idle  = 1'b0;
    hold_len = HOLD_CYCLES;
    run_stream(64, 1'b0);

    while (rand_items < RANDOM_ITEMS) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if ($urandom_range(0, 11) == 0) setting[i] = '0;
        else if (i == CFG_CHANNELS) setting[i] = $urandom_range(1, 3);
        else if (i <= CFG_WIDTH) setting[i] = $urandom_range(1, 10);
        else if ($urandom_range(0, 9) == 0) setting[i] = $urandom_range(9, 15);
        else setting[i] = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 8 : 4);
      end
      program_regs(setting);
      plane = eff(setting[CFG_CHANNELS], DIM_LIMIT) * eff(setting[CFG_HEIGHT], DIM_LIMIT)
              * eff(setting[CFG_WIDTH], MAX_WIDTH);
      burst = plane * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) burst = $urandom_range(1, plane);
      run_stream(burst, 1'b1);
      rand_items += burst;
    end
    settle();

    $display("Summary: %0d samples, %0d pooled beats (%0d tensor ends), %0d register writes",
             samples_in, results_out, lasts_seen, reg_writes);
    $display("Summary: %0d settings incl. clamped, zero and oversized-window cases, %0d errors",
             phases, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
